>>> hdl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int MAG_W         = 32;   // magnitude width fed to the cell row
    localparam int NUM_DIGITS    = 10;   // decimal cells in the row
    localparam int NARROW_DIGITS = 5;    // digits printed in 16-bit modes
    localparam int STEP_BITS     = 4;    // magnitude bits taken per cycle
    localparam int CONV_STEPS    = MAG_W / STEP_BITS;
    localparam int CNT_W         = $clog2(CONV_STEPS);
    localparam int LEFT_W        = $clog2(NUM_DIGITS + 1);
    localparam int DIG_W         = 4 * NUM_DIGITS;

    localparam logic [7:0]        CHAR_ZERO  = 8'h30;
    localparam logic [7:0]        CHAR_MINUS = 8'h2D;
    localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(CONV_STEPS - 1);
    localparam logic [LEFT_W-1:0] LEFT_WIDE  = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_NARROW = LEFT_W'(NARROW_DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_ONE   = LEFT_W'(1);

    // Finished conversion handed from the cell row to the character emitter.
    typedef struct packed {
        logic [DIG_W-1:0] digits;  // cell i at [4i+3:4i], cell 0 = ones
        logic             neg;
        logic             wide;
    } t_conv_res;

endpackage

>>> hdl/b2da_cell.sv
// One BCD digit cell of the shift-and-add-3 row; takes four bits a cycle while enabled.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_cell (
    input  logic                          i_clk,
    input  logic                          i_clr,
    input  logic                          i_en,
    input  logic [b2da_pkg::STEP_BITS-1:0] i_bits,   // [msb] enters first
    output logic [b2da_pkg::STEP_BITS-1:0] o_bits,   // carries to next cell
    output logic [3:0]                    o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;

    always_comb begin
        logic [3:0] v;
        logic [3:0] a;
        v = r_digit;
        a = '0;
        for (int k = b2da_pkg::STEP_BITS - 1; k >= 0; k--) begin
            a = (v >= 4'd5) ? v + 4'd3 : v;
            o_bits[k] = a[3];
            v = {a[2:0], i_bits[k]};
        end
        n_digit = v;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_digit <= '0;
        end else if (i_en) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

>>> hdl/b2da_conv.sv
// Binary to BCD converter: a row of digit cells fed four magnitude bits a cycle.
// Depends on b2da_pkg and b2da_cell.
`timescale 1ns / 1ps

module b2da_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [b2da_pkg::MAG_W-1:0]  i_mag,
    input  logic                        i_neg,
    input  logic                        i_wide,
    output logic                        o_valid,
    input  logic                        i_ready,
    output b2da_pkg::t_conv_res         o_res
);

    localparam int SB = b2da_pkg::STEP_BITS;
    localparam int ND = b2da_pkg::NUM_DIGITS;

    logic                        r_act;
    logic                        r_done;
    logic [b2da_pkg::CNT_W-1:0]  r_cnt;
    logic [b2da_pkg::MAG_W-1:0]  r_sreg;
    logic                        r_neg;
    logic                        r_wide;
    logic                        w_load;
    logic [SB-1:0]               w_carry [0:ND-1];
    logic [b2da_pkg::DIG_W-1:0]  w_digits;

    assign o_ready = !r_act && (!r_done || i_ready);
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_done;

    assign w_carry[0] = r_sreg[b2da_pkg::MAG_W-1 -: SB];

    for (genvar i = 0; i < ND; i++) begin : g_cell
        if (i < ND - 1) begin : g_mid
            b2da_cell u_cell (
                .i_clk   (i_clk),
                .i_clr   (w_load),
                .i_en    (r_act),
                .i_bits  (w_carry[i]),
                .o_bits  (w_carry[i+1]),
                .o_digit (w_digits[4*i +: 4])
            );
        end else begin : g_top
            b2da_cell u_cell (
                .i_clk   (i_clk),
                .i_clr   (w_load),
                .i_en    (r_act),
                .i_bits  (w_carry[i]),
                .o_bits  (),
                .o_digit (w_digits[4*i +: 4])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_act  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_act) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == b2da_pkg::LAST_STEP) begin
                r_act  <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_done && i_ready) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sreg <= i_mag;
            r_neg  <= i_neg;
            r_wide <= i_wide;
        end else if (r_act) begin
            r_sreg <= {r_sreg[b2da_pkg::MAG_W-SB-1:0], {SB{1'b0}}};
        end
    end

    assign o_res.digits = w_digits;
    assign o_res.neg    = r_neg;
    assign o_res.wide   = r_wide;

    a_act_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_act && r_done))
        else $error("converter running and done at once");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_act) && !$past(w_load) |-> r_done)
        else $error("conversion finished without raising done");

endmodule

>>> hdl/b2da_emit.sv
// Character emitter: sends the optional minus and the digits, one beat each.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b2da_pkg::t_conv_res i_res,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_char,
    output logic                o_last
);

    localparam int DW = b2da_pkg::DIG_W;
    localparam int NW = 4 * b2da_pkg::NARROW_DIGITS;

    logic                         r_busy;
    logic                         r_minus;
    logic [b2da_pkg::LEFT_W-1:0]  r_left;
    logic [DW-1:0]                r_dig;
    logic                         w_load;
    logic                         w_take;

    assign o_valid = r_busy;
    assign o_char  = r_minus ? b2da_pkg::CHAR_MINUS
                             : b2da_pkg::CHAR_ZERO + {4'b0000, r_dig[DW-1 -: 4]};
    assign o_last  = !r_minus && (r_left == b2da_pkg::LEFT_ONE);
    assign w_take  = r_busy && i_ready;
    assign o_ready = !r_busy || (i_ready && o_last);
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_minus <= 1'b0;
            r_left  <= '0;
        end else if (w_load) begin
            r_busy  <= 1'b1;
            r_minus <= i_res.neg;
            r_left  <= i_res.wide ? b2da_pkg::LEFT_WIDE : b2da_pkg::LEFT_NARROW;
        end else if (w_take) begin
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_left <= r_left - 1'b1;
                if (r_left == b2da_pkg::LEFT_ONE) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Most significant printed digit sits at the top nibble.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dig <= i_res.wide ? i_res.digits : {i_res.digits[NW-1:0], {(DW-NW){1'b0}}};
        end else if (w_take && !r_minus) begin
            r_dig <= {r_dig[DW-5:0], 4'b0000};
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0) && (r_left <= b2da_pkg::LEFT_WIDE))
        else $error("digit count out of range");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_minus |-> (r_left == b2da_pkg::LEFT_WIDE) ||
                              (r_left == b2da_pkg::LEFT_NARROW))
        else $error("minus sign pending after a digit was sent");

    a_digit_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_minus |-> r_dig[DW-1 -: 4] <= 4'd9)
        else $error("digit nibble is not decimal");

endmodule

>>> hdl/binary_to_decimal_ascii.sv
// The first character of an item follows its cell shifts of four bits and the handoff to
//   the emitter, once the emitter is free. The cell row takes a new value only when it is
//   not converting and the emitter takes or has taken its last result. An item is 5, 6, 10
//   or 11 characters; the cell row converts one item while the emitter sends the previous one.
// Reset: i_rst_n synchronous, active low; clears control and sets format_mode to 0.
// Depends on b2da_pkg, b2da_conv, b2da_cell and b2da_emit.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write: format_mode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_value,
    // output beats, one character each
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    // format_mode: 0 = 16-bit unsigned, 1 = 16-bit signed, 2 or 3 = 32-bit signed
    logic [1:0]                 r_mode;
    logic                       w_wide;
    logic                       w_signed;
    logic [31:0]                w_sval;
    logic                       w_neg;
    logic [b2da_pkg::MAG_W-1:0] w_mag;

    logic                       w_res_valid;
    logic                       w_res_ready;
    b2da_pkg::t_conv_res        w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Magnitude and sign. Negating in 32 bits gives the true magnitude of the
    // most negative value of either width (0x80000000 reads as 2^31 unsigned).
    assign w_wide   = r_mode[1];
    assign w_signed = r_mode[1] | r_mode[0];
    assign w_sval   = w_wide   ? i_value :
                      w_signed ? {{16{i_value[15]}}, i_value[15:0]} :
                                 {16'h0000, i_value[15:0]};
    assign w_neg    = w_signed && w_sval[31];
    assign w_mag    = w_neg ? (32'd0 - w_sval) : w_sval;

    // Cell row: ten BCD cells, four magnitude bits shifted in per cycle.
    b2da_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mag   (w_mag),
        .i_neg   (w_neg),
        .i_wide  (w_wide),
        .o_valid (w_res_valid),
        .i_ready (w_res_ready),
        .o_res   (w_res)
    );

    // Emitter: holds one finished number and sends it a character per beat,
    // so the cell row can start on the next value meanwhile.
    b2da_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_res   (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_char  (o_out_char),
        .o_last  (o_last)
    );

endmodule

>>> bench/tb_binary_to_decimal_ascii.sv
// Testbench for binary_to_decimal_ascii: directed and random values in all format modes.
// The scoreboard predicts the decimal text of each accepted value and checks every character.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;

    // format_mode codes; code 3 is unused and prints like the 32-bit signed mode
    localparam logic [1:0] MODE_U16     = 2'd0;
    localparam logic [1:0] MODE_S16     = 2'd1;
    localparam logic [1:0] MODE_S32     = 2'd2;
    localparam logic [1:0] MODE_S32_ALT = 2'd3;

    localparam int IDLE_PCT     = 8;    // chance per cycle that a side idles
    localparam int SETTLE_CYC   = 12;   // a bit more than one item's latency
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    // Keeps the mode copy and the characters still owed by the block.
    class decimal_text_board;
        logic [1:0]  format_mode = MODE_U16;
        t_char_beat  pending_chars[$];
        int unsigned mismatches = 0;

        // Expand one accepted value into its expected characters.
        function void add_value(logic [31:0] value);
            logic [31:0] mag;
            logic        neg;
            int          ndig;
            logic [3:0]  digit_q[$];
            t_char_beat  beat;
            neg = 1'b0;
            if (format_mode == MODE_U16) begin
                mag  = {16'h0, value[15:0]};
                ndig = b2da_pkg::NARROW_DIGITS;
            end else if (format_mode == MODE_S16) begin
                neg  = value[15];
                // true magnitude, so -32768 needs no special case
                mag  = neg ? 32'h1_0000 - {16'h0, value[15:0]} : {16'h0, value[15:0]};
                ndig = b2da_pkg::NARROW_DIGITS;
            end else begin
                neg  = value[31];
                mag  = neg ? -value : value;   // 0x8000_0000 stays 2^31 unsigned
                ndig = b2da_pkg::NUM_DIGITS;
            end
            if (neg) begin
                beat.ch   = b2da_pkg::CHAR_MINUS;
                beat.last = 1'b0;
                pending_chars.push_back(beat);
            end
            // least significant digit first, then emitted in reverse
            for (int i = 0; i < ndig; i++) begin
                digit_q.push_front(4'(mag % 10));
                mag = mag / 10;
            end
            for (int i = 0; i < ndig; i++) begin
                beat.ch   = b2da_pkg::CHAR_ZERO + {4'h0, digit_q[i]};
                beat.last = (i == ndig - 1);
                pending_chars.push_back(beat);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_char_beat want;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected character 0x%02h last=%0b", $realtime, ch, last);
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch || last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             $realtime, want.ch, want.last, ch, last);
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data  = MODE_U16;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_value     = 32'h0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_last;

    // While set, neither side idles: gives a long back-to-back stretch.
    bit quiet = 1'b0;

    decimal_text_board text_board = new();

    binary_to_decimal_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit take_pause();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Receiver: random back-pressure, one update per rising edge.
    always @(posedge i_clk) begin
        i_out_ready <= !take_pause();
    end

    // Everything settles between rising edges, so sampling at the falling edge
    // sees exactly what the next rising edge will accept.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            text_board.check_char(o_out_char, o_last);
    end

    // Mode write; only called with the block idle.
    task automatic write_mode(input logic [1:0] mode);
        logic rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        text_board.format_mode = mode;
    endtask

    // Send one value beat; random idle cycles come first, while valid is low.
    task automatic send_value(input logic [31:0] value);
        logic rdy;
        while (take_pause()) begin
            i_in_valid <= 1'b0;
            i_value    <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        do begin
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end while (!rdy);
        text_board.add_value(value);
    endtask

    // Stop sending and wait until every owed character has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (text_board.pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Random value leaning on the interesting corners of the current mode.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 99);
            1: v = -$urandom_range(1, 99);
            2: v = {v[31:16], 16'h8000 + 16'($urandom_range(0, 3)) - 16'd2};
            3: v = 32'h8000_0000 + $urandom_range(0, 3) - 2;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [1:0] rand_modes [4];
        rand_modes = '{MODE_S16, MODE_S32_ALT, MODE_U16, MODE_S32};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset mode is unsigned 16-bit; upper bits of value must be ignored.
        send_value(32'h0000_0000);
        send_value(32'h0000_FFFF);          // 65535, leading digit 6
        send_value(32'hFFFF_0000);          // prints 00000
        send_value(32'h1234_2710);          // 10000
        send_value(32'h0000_270F);          // 09999
        drain();

        write_mode(MODE_S16);
        send_value(32'h0000_0000);
        send_value(32'h0000_7FFF);          // 32767
        send_value(32'h0000_8000);          // -32768, most negative
        send_value(32'hABCD_FFFF);          // -1
        send_value(32'h7FFF_0001);          // 00001
        drain();

        write_mode(MODE_S32);
        send_value(32'h0000_0000);
        send_value(32'h7FFF_FFFF);          // 2147483647
        send_value(32'h8000_0000);          // -2147483648, most negative
        send_value(32'hFFFF_FFFF);          // -1
        send_value(32'd1_000_000_000);
        send_value(-32'd999_999_999);
        drain();

        // Unused code must act like the 32-bit signed mode.
        write_mode(MODE_S32_ALT);
        send_value(32'h8000_0000);
        send_value(32'h0000_FFFF);
        send_value(32'h1234_5678);

        // Random phases; the third runs with no idling on either side.
        foreach (rand_modes[p]) begin
            drain();
            write_mode(rand_modes[p]);
            quiet = (p == 2);
            for (int k = 0; k < 25; k++) begin
                // one pause mid-phase until the output side has caught up
                if (p == 1 && k == 12)
                    drain();
                send_value(pick_value());
            end
        end
        quiet = 1'b0;
        drain();

        if (text_board.pending_chars.size() != 0)
            $display("%0d characters never came out", text_board.pending_chars.size());
        if (text_board.mismatches == 0 && text_board.pending_chars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/b2da_pkg.sv
hdl/b2da_cell.sv
hdl/b2da_conv.sv
hdl/b2da_emit.sv
hdl/binary_to_decimal_ascii.sv
bench/tb_binary_to_decimal_ascii.sv
